// ----- design/wqhb_pkg.sv -----
// Shared types, constants and a helper function for the worker queue with heartbeat expiry.
package wqhb_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int ADDR_W        = $clog2(QUEUE_DEPTH);
    localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W          = 32;
    localparam int TIME_W        = 32;
    localparam int TIMEOUT_W     = 16;
    localparam int COUNT_OUT_W   = 5;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd3000;

    typedef enum logic [2:0] {
        CMD_ADD     = 3'd0,
        CMD_REMOVE  = 3'd1,
        CMD_REFRESH = 3'd2,
        CMD_POP     = 3'd3,
        CMD_PURGE   = 3'd4,
        CMD_BEAT    = 3'd5,
        CMD_CLEAR   = 3'd6,
        CMD_TICK    = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_DONE   = 3'd0,
        KIND_POPPED = 3'd1,
        KIND_BEAT   = 3'd2,
        KIND_DUP    = 3'd3,
        KIND_FULL   = 3'd4,
        KIND_EMPTY  = 3'd5,
        KIND_NOBEAT = 3'd6
    } t_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        t_cmd op;
        logic scan;
        logic finish;
        logic beat_rd;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             count_zero;
        logic             full;
        logic             beat_due;
        logic             scan_done;
        logic             found;
        logic             beat_last;
        logic [ID_W-1:0]  rd_id;
        logic [ID_W-1:0]  pop_id;
    } t_dp_stat;

    typedef struct packed {
        t_kind                  kind;
        logic [ID_W-1:0]        worker_id;
        logic                   queue_empty;
        logic [COUNT_OUT_W-1:0] queue_count;
        logic                   last;
    } t_result;

    // A time has passed a mark when the wrapping difference is positive.
    function automatic logic has_passed(input logic [TIME_W-1:0] t,
                                        input logic [TIME_W-1:0] mark);
        logic [TIME_W-1:0] d;
        d = t - mark;
        return (d != '0) && !d[TIME_W-1];
    endfunction

endpackage

// ----- design/wqhb_if.sv -----
// Valid/ready channel interfaces for commands and results.
interface wqhb_in_if;
    logic                        valid;
    logic                        ready;
    wqhb_pkg::t_cmd              cmd;
    logic [wqhb_pkg::ID_W-1:0]   worker_id;

    modport source (output valid, output cmd, output worker_id, input ready);
    modport sink   (input valid, input cmd, input worker_id, output ready);
endinterface

interface wqhb_out_if;
    logic                             valid;
    logic                             ready;
    wqhb_pkg::t_kind                  kind;
    logic [wqhb_pkg::ID_W-1:0]        out_worker_id;
    logic                             queue_empty;
    logic [wqhb_pkg::COUNT_OUT_W-1:0] queue_count;
    logic                             last;

    modport source (output valid, output kind, output out_worker_id, output queue_empty,
                    output queue_count, output last, input ready);
    modport sink   (input valid, input kind, input out_worker_id, input queue_empty,
                    input queue_count, input last, output ready);
endinterface

// ----- design/wqhb_dp.sv -----
// Datapath: queue storage, time and deadline registers, scan pointers and compare logic.
module wqhb_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wqhb_pkg::TIMEOUT_W-1:0]    i_cfg_wdata,
    input  logic [wqhb_pkg::ID_W-1:0]         i_wid,
    input  wqhb_pkg::t_dp_cmd                 i_cmd,
    output wqhb_pkg::t_dp_stat                o_stat
);

    logic [wqhb_pkg::ID_W-1:0]      r_id_mem  [wqhb_pkg::QUEUE_DEPTH];
    logic [wqhb_pkg::TIME_W-1:0]    r_exp_mem [wqhb_pkg::QUEUE_DEPTH];

    logic [wqhb_pkg::CNT_W-1:0]     r_count;
    logic [wqhb_pkg::TIME_W-1:0]    r_now;
    logic [wqhb_pkg::TIME_W-1:0]    r_deadline;
    logic [wqhb_pkg::TIMEOUT_W-1:0] r_timeout;
    logic [wqhb_pkg::CNT_W-1:0]     r_rd;
    logic [wqhb_pkg::CNT_W-1:0]     r_wr;
    logic                           r_dv;
    logic                           r_found;
    logic [wqhb_pkg::ADDR_W-1:0]    r_pa;
    logic [wqhb_pkg::ID_W-1:0]      r_wid;
    logic [wqhb_pkg::ID_W-1:0]      r_rd_id;
    logic [wqhb_pkg::TIME_W-1:0]    r_rd_exp;
    logic [wqhb_pkg::ID_W-1:0]      r_pop_id;

    logic [wqhb_pkg::TIME_W-1:0]    w_new_exp;
    logic                           w_issue;
    logic                           w_re;
    logic [wqhb_pkg::ADDR_W-1:0]    w_ra;
    logic                           w_eval;
    logic                           w_hit;
    logic                           w_filter;
    logic                           w_drop;
    logic                           w_keep;
    logic                           w_full;
    logic                           w_add_ok;
    logic                           w_we_id;
    logic                           w_we_exp;
    logic [wqhb_pkg::ADDR_W-1:0]    w_wa;
    logic [wqhb_pkg::ID_W-1:0]      w_wd_id;
    logic [wqhb_pkg::TIME_W-1:0]    w_wd_exp;

    assign w_new_exp = r_now + wqhb_pkg::TIME_W'(r_timeout);
    assign w_issue   = i_cmd.scan && (r_rd < r_count);
    assign w_re      = w_issue || i_cmd.beat_rd;
    assign w_ra      = r_rd[wqhb_pkg::ADDR_W-1:0];
    assign w_eval    = i_cmd.scan && r_dv;
    assign w_hit     = (r_rd_id == r_wid);
    assign w_full    = (r_count == wqhb_pkg::CNT_W'(wqhb_pkg::QUEUE_DEPTH));
    assign w_add_ok  = (i_cmd.op == wqhb_pkg::CMD_ADD) && !r_found && !w_full;
    assign w_filter  = (i_cmd.op == wqhb_pkg::CMD_REMOVE) || (i_cmd.op == wqhb_pkg::CMD_POP)
                    || (i_cmd.op == wqhb_pkg::CMD_PURGE);

    always_comb begin
        case (i_cmd.op)
            wqhb_pkg::CMD_REMOVE: w_drop = w_hit;
            wqhb_pkg::CMD_POP:    w_drop = (r_pa == '0);
            wqhb_pkg::CMD_PURGE:  w_drop = wqhb_pkg::has_passed(r_now, r_rd_exp);
            default:              w_drop = 1'b0;
        endcase
    end

    assign w_keep = w_eval && w_filter && !w_drop;

    // Single write port: compaction, refresh of the first match, or append on add.
    always_comb begin
        w_we_id  = 1'b0;
        w_we_exp = 1'b0;
        w_wa     = r_wr[wqhb_pkg::ADDR_W-1:0];
        w_wd_id  = r_rd_id;
        w_wd_exp = r_rd_exp;
        if (w_keep) begin
            w_we_id  = 1'b1;
            w_we_exp = 1'b1;
        end else if (w_eval && (i_cmd.op == wqhb_pkg::CMD_REFRESH) && w_hit && !r_found) begin
            w_we_exp = 1'b1;
            w_wa     = r_pa;
            w_wd_exp = w_new_exp;
        end else if (i_cmd.finish && w_add_ok) begin
            w_we_id  = 1'b1;
            w_we_exp = 1'b1;
            w_wa     = r_count[wqhb_pkg::ADDR_W-1:0];
            w_wd_id  = r_wid;
            w_wd_exp = w_new_exp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_now      <= '0;
            r_deadline <= '0;
            r_timeout  <= wqhb_pkg::TIMEOUT_RESET;
            r_rd       <= '0;
            r_wr       <= '0;
            r_dv       <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                r_rd    <= '0;
                r_wr    <= '0;
                r_dv    <= 1'b0;
                r_found <= 1'b0;
                case (i_cmd.op)
                    wqhb_pkg::CMD_TICK:  r_now   <= r_now + 1'b1;
                    wqhb_pkg::CMD_CLEAR: r_count <= '0;
                    wqhb_pkg::CMD_BEAT: begin
                        if (wqhb_pkg::has_passed(r_now, r_deadline)) begin
                            r_deadline <= w_new_exp;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.scan) begin
                r_rd <= r_rd + wqhb_pkg::CNT_W'(w_issue);
                r_dv <= w_issue;
                if (w_keep) begin
                    r_wr <= r_wr + 1'b1;
                end
                if (w_eval && w_hit && ((i_cmd.op == wqhb_pkg::CMD_ADD)
                                     || (i_cmd.op == wqhb_pkg::CMD_REFRESH))) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.beat_rd) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_cmd.finish) begin
                if (w_filter) begin
                    r_count <= r_wr;
                end else if (w_add_ok) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_wid <= i_wid;
        end
        if (w_re) begin
            r_rd_id  <= r_id_mem[w_ra];
            r_rd_exp <= r_exp_mem[w_ra];
            r_pa     <= w_ra;
        end
        if (w_eval && (r_pa == '0)) begin
            r_pop_id <= r_rd_id;
        end
        if (w_we_id) begin
            r_id_mem[w_wa] <= w_wd_id;
        end
        if (w_we_exp) begin
            r_exp_mem[w_wa] <= w_wd_exp;
        end
    end

    always_comb begin
        o_stat.count      = r_count;
        o_stat.count_zero = (r_count == '0);
        o_stat.full       = w_full;
        o_stat.beat_due   = wqhb_pkg::has_passed(r_now, r_deadline);
        o_stat.scan_done  = !w_issue && !r_dv;
        o_stat.found      = r_found;
        o_stat.beat_last  = (r_rd == r_count);
        o_stat.rd_id      = r_rd_id;
        o_stat.pop_id     = r_pop_id;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= wqhb_pkg::CNT_W'(wqhb_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");
    a_wr_behind_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> (r_wr <= r_rd))
        else $error("compaction write pointer passed read pointer");
    a_finish_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> !r_dv)
        else $error("scan finished with read data pending");
`endif

endmodule

// ----- design/wqhb_out.sv -----
// Result holding register that drives the result channel.
module wqhb_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  wqhb_pkg::t_result  i_result,
    output logic               o_free,
    wqhb_out_if.source         o_out
);

    logic              r_valid;
    wqhb_pkg::t_result r_result;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.kind          = r_result.kind;
    assign o_out.out_worker_id = r_result.worker_id;
    assign o_out.queue_empty   = r_result.queue_empty;
    assign o_out.queue_count   = r_result.queue_count;
    assign o_out.last          = r_result.last;

endmodule

// ----- design/wqhb_ctrl.sv -----
// Controller state machine that sequences each command over the datapath.
module wqhb_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  wqhb_pkg::t_cmd      i_in_cmd,
    output logic                o_in_ready,
    output wqhb_pkg::t_dp_cmd   o_dp_cmd,
    input  wqhb_pkg::t_dp_stat  i_stat,
    input  logic                i_out_free,
    output logic                o_out_load,
    output wqhb_pkg::t_result   o_result
);

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_SCAN      = 6'b000010,
        S_FINISH    = 6'b000100,
        S_BEAT_RD   = 6'b001000,
        S_BEAT_WAIT = 6'b010000,
        S_RESP      = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    wqhb_pkg::t_cmd  r_op, n_op;
    wqhb_pkg::t_kind r_kind, n_kind;
    logic            w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        o_dp_cmd.accept  = w_accept;
        o_dp_cmd.op      = w_accept ? i_in_cmd : r_op;
        o_dp_cmd.scan    = (r_state == S_SCAN);
        o_dp_cmd.finish  = (r_state == S_FINISH);
        o_dp_cmd.beat_rd = (r_state == S_BEAT_RD);
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_kind     = r_kind;
        o_out_load = 1'b0;

        o_result.kind        = r_kind;
        o_result.worker_id   = (r_kind == wqhb_pkg::KIND_POPPED) ? i_stat.pop_id : '0;
        o_result.queue_empty = i_stat.count_zero;
        o_result.queue_count = wqhb_pkg::COUNT_OUT_W'(i_stat.count);
        o_result.last        = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op = i_in_cmd;
                    case (i_in_cmd)
                        wqhb_pkg::CMD_ADD, wqhb_pkg::CMD_REMOVE,
                        wqhb_pkg::CMD_REFRESH, wqhb_pkg::CMD_PURGE: begin
                            n_state = S_SCAN;
                        end
                        wqhb_pkg::CMD_POP: begin
                            if (i_stat.count_zero) begin
                                n_kind  = wqhb_pkg::KIND_EMPTY;
                                n_state = S_RESP;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        wqhb_pkg::CMD_BEAT: begin
                            if (!i_stat.beat_due) begin
                                n_kind  = wqhb_pkg::KIND_NOBEAT;
                                n_state = S_RESP;
                            end else if (i_stat.count_zero) begin
                                n_kind  = wqhb_pkg::KIND_DONE;
                                n_state = S_RESP;
                            end else begin
                                n_state = S_BEAT_RD;
                            end
                        end
                        default: begin
                            n_kind  = wqhb_pkg::KIND_DONE;
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                case (r_op)
                    wqhb_pkg::CMD_ADD: begin
                        if (i_stat.found) begin
                            n_kind = wqhb_pkg::KIND_DUP;
                        end else if (i_stat.full) begin
                            n_kind = wqhb_pkg::KIND_FULL;
                        end else begin
                            n_kind = wqhb_pkg::KIND_DONE;
                        end
                    end
                    wqhb_pkg::CMD_POP: n_kind = wqhb_pkg::KIND_POPPED;
                    default:           n_kind = wqhb_pkg::KIND_DONE;
                endcase
                n_state = S_RESP;
            end
            S_BEAT_RD: begin
                n_state = S_BEAT_WAIT;
            end
            S_BEAT_WAIT: begin
                o_result.kind      = wqhb_pkg::KIND_BEAT;
                o_result.worker_id = i_stat.rd_id;
                o_result.last      = i_stat.beat_last;
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = i_stat.beat_last ? S_IDLE : S_BEAT_RD;
                end
            end
            S_RESP: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= wqhb_pkg::CMD_TICK;
            r_kind  <= wqhb_pkg::KIND_DONE;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_kind  <= n_kind;
        end
    end

`ifndef SYNTH
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("controller stayed idle after a transfer");
    a_beat_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BEAT_RD) |-> !i_stat.count_zero)
        else $error("heartbeat walk on an empty queue");
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_load |-> i_out_free)
        else $error("result loaded over a pending result");
`endif

endmodule

// ----- design/worker_queue_heartbeat_expiry_core.sv -----
// Top level of the worker queue with heartbeat expiry.
// This block keeps an ordered queue of up to sixteen worker IDs, each with an expiry time
// kept against a local tick counter, and answers one command per input transfer. The
// queue sits in two storage arrays sharing one registered read port and one write port,
// so every command that must look at the entries walks them one per cycle: add, remove,
// refresh, pop and purge each walk every queued worker (remove, pop and purge compact the
// queue in the same walk). A heartbeat that fires reads the workers one at a time, the
// next only once the last result is in the output register, and emits one result transfer
// per worker, oldest first, with last set on the final one; tick, clear, an early
// heartbeat, a due heartbeat on an empty queue and a pop of an empty queue answer with a
// single result and no walk. One command is in progress at a time; the next input
// transfer is taken as soon as the last result of the current command has been handed to
// the output register, even if that result is still waiting on the result channel. Times
// compare by wrapping difference, so the tick counter may roll over freely. The timeout
// register (reset value 3000 ticks) sets both the expiry of added or refreshed workers and
// the heartbeat interval; write it only while the block is idle. Queue storage is not
// cleared at reset; only entries below the queue count are ever read.
module worker_queue_heartbeat_expiry_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [wqhb_pkg::TIMEOUT_W-1:0] i_cfg_wdata,
    wqhb_in_if.sink                        i_in,
    wqhb_out_if.source                     o_out
);

    wqhb_pkg::t_dp_cmd  w_dp_cmd;
    wqhb_pkg::t_dp_stat w_stat;
    wqhb_pkg::t_result  w_result;
    logic               w_out_free;
    logic               w_out_load;
    logic               w_in_ready;

    // Input channel is ready only while the controller is idle.
    assign i_in.ready = w_in_ready;

    wqhb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .o_in_ready (w_in_ready),
        .o_dp_cmd   (w_dp_cmd),
        .i_stat     (w_stat),
        .i_out_free (w_out_free),
        .o_out_load (w_out_load),
        .o_result   (w_result)
    );

    // The datapath latches the worker ID on the input transfer.
    wqhb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_wid       (i_in.worker_id),
        .i_cmd       (w_dp_cmd),
        .o_stat      (w_stat)
    );

    // Output register decouples result delivery from the command sequencing.
    wqhb_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_out_load),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_out    (o_out)
    );

endmodule
